// ===== hw/rtl/rfp_pkg.sv =====
// Package: shared types and constants for the foothold planner.
package rfp_pkg;

  localparam int BODY_WORDS = 21;
  localparam int SLOT_POS_Z = 11;

  // Configuration register indexes.
  localparam logic [1:0] REG_STANCE = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_HIP_X  = 2'd2;
  localparam logic [1:0] REG_HIP_Y  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_MAC,
    ST_SAT_PF,
    ST_TANG,
    ST_TGT,
    ST_OUT
  } rfp_state_t;

  // Sources of the two multiplier operands.
  typedef enum logic [2:0] {
    SA_BODY,
    SA_STANCE,
    SA_GAIN,
    SA_ROOT
  } rfp_asel_t;

  typedef enum logic [2:0] {
    SB_FOOT,
    SB_PF,
    SB_HIP,
    SB_BODY,
    SB_VELERR,
    SB_TANG
  } rfp_bsel_t;

  // Where a saturated accumulator lands.
  typedef enum logic [1:0] {
    DST_PF,
    DST_TANG,
    DST_TGT
  } rfp_dst_t;

  // Controller to datapath.
  typedef struct packed {
    logic       start;      // latch item fields
    logic       root_start; // start square root
    logic       mac_en;     // accumulate one product
    rfp_asel_t  asel;
    rfp_bsel_t  bsel;
    logic [4:0] aidx;       // body word index for operand A
    logic [4:0] bidx;       // body word or vector index for operand B
    logic       half;       // extra shift for the T/2 factor
    logic       neg;        // subtract product
    logic       acc_clr;    // clear accumulator
    logic       add_body;   // add body word bidx directly (position)
    rfp_dst_t   dst;
    logic [1:0] dst_idx;
    logic       store;      // saturate accumulator into dst
  } rfp_cmd_t;

  typedef struct packed {
    logic root_done;
  } rfp_sts_t;

endpackage

// ===== hw/rtl/raibert_foothold_planner.sv =====
// Top level: Raibert-heuristic foothold planner.
//
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tdata, tuser = mode
//  m_axis  | out | m_axis_tvalid/tready   | tdata
//  cfg     | in  | cfg_we                 | cfg_idx, cfg_data
//
// Mode 0 items and items that plan nothing do not stall the input.
// A planned leg runs the bit-per-cycle square root of the pendulum term, then the pf,
// tang and target steps of the sequencer on one multiplier, and then raises m_axis_tvalid.
// The input stalls while a plan runs or its result waits on m_axis_tready.
// rst is synchronous; it loads the configuration register defaults and clears the leg phase tracking and the sequencer.
module raibert_foothold_planner #(
  parameter int NUM_LEGS  = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot[4:0], value[36:5], leg[38:37], swing[39], foot_x[71:40],
  // foot_y[103:72], foot_z[135:104]
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // planned_leg[1:0], target_x[33:2], target_y[65:34], zero fill
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [19:0]  cfg_data
);
  import rfp_pkg::*;

  localparam int LW = $clog2(NUM_LEGS);

  logic [4:0]  in_slot;
  logic signed [31:0] in_value, fx, fy, fz;
  logic [1:0]  in_leg;
  logic        in_swing, accept, busy, go;
  assign in_slot  = s_axis_tdata[4:0];
  assign in_value = s_axis_tdata[36:5];
  assign in_leg   = s_axis_tdata[38:37];
  assign in_swing = s_axis_tdata[39];
  assign fx = s_axis_tdata[71:40];
  assign fy = s_axis_tdata[103:72];
  assign fz = s_axis_tdata[135:104];

  logic [19:0] stance_time;
  logic [16:0] velocity_gain, hip_x_offset, hip_y_offset;
  always_ff @(posedge clk) begin
    if (rst) begin
      stance_time   <= 20'd32768;
      velocity_gain <= 17'd655;
      hip_x_offset  <= 17'd12845;
      hip_y_offset  <= 17'd8323;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_STANCE: stance_time   <= cfg_data;
        REG_GAIN:   velocity_gain <= cfg_data[16:0];
        REG_HIP_X:  hip_x_offset  <= cfg_data[16:0];
        REG_HIP_Y:  hip_y_offset  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic [NUM_LEGS-1:0] prev_swing, leg_known;
  logic leg_ok, plan;
  logic [LW-1:0] leg_i;
  assign leg_i  = LW'(in_leg);
  assign leg_ok = 32'(in_leg) < NUM_LEGS;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy;
  assign plan = leg_known[leg_i] ? (!prev_swing[leg_i] && in_swing) : in_swing;
  assign go   = accept && s_axis_tuser && leg_ok && plan;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_swing <= '0;
      leg_known  <= '0;
    end else if (accept && s_axis_tuser && leg_ok) begin
      prev_swing[leg_i] <= in_swing;
      leg_known[leg_i]  <= 1'b1;
    end
  end

  rfp_cmd_t cmd;
  rfp_sts_t sts;
  logic signed [31:0] tx, ty;
  logic [1:0] out_leg;

  always_ff @(posedge clk) if (go) out_leg <= in_leg;

  rfp_ctrl u_ctrl (
    .clk, .rst, .go, .out_taken(m_axis_tready), .sts, .cmd, .busy,
    .out_valid(m_axis_tvalid)
  );

  rfp_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .wr_en(accept && !s_axis_tuser && in_slot < 5'(BODY_WORDS)),
    .wr_slot(in_slot), .wr_value(in_value), .in_leg(in_leg),
    .in_foot_x(fx), .in_foot_y(fy), .in_foot_z(fz),
    .stance_time, .velocity_gain, .hip_x_offset, .hip_y_offset,
    .target_x(tx), .target_y(ty)
  );

  assign m_axis_tdata = {6'd0, ty, tx, out_leg};

  assert property (@(posedge clk) disable iff (rst) go |=> !s_axis_tready)
    else $error("input not stalled after plan start");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

endmodule

// ===== hw/rtl/rfp_dp.sv =====
// Datapath: body word memory, multiply-accumulate, square root and result registers.
module rfp_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rfp_pkg::rfp_cmd_t     cmd,
  output rfp_pkg::rfp_sts_t     sts,
  input  logic                  wr_en,
  input  logic [4:0]            wr_slot,
  input  logic signed [31:0]    wr_value,
  input  logic [1:0]            in_leg,
  input  logic signed [31:0]    in_foot_x,
  input  logic signed [31:0]    in_foot_y,
  input  logic signed [31:0]    in_foot_z,
  input  logic [19:0]           stance_time,
  input  logic [16:0]           velocity_gain,
  input  logic [16:0]           hip_x_offset,
  input  logic [16:0]           hip_y_offset,
  output logic signed [31:0]    target_x,
  output logic signed [31:0]    target_y
);
  import rfp_pkg::*;

  localparam int ACCW = 72;

  logic signed [31:0] body [BODY_WORDS];
  logic signed [31:0] foot [3];
  logic signed [31:0] pf [3];
  logic signed [31:0] tang [2];
  logic [1:0]         leg;
  logic signed [ACCW-1:0] acc;
  logic signed [32:0] root;
  logic signed [31:0] body_a, body_b;

  always_ff @(posedge clk) begin
    if (wr_en) body[wr_slot] <= wr_value;
  end
  assign body_a = body[cmd.aidx];
  assign body_b = body[cmd.bidx];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      foot[0] <= in_foot_x;
      foot[1] <= in_foot_y;
      foot[2] <= in_foot_z;
      leg     <= in_leg;
    end
  end

  // Pendulum root: largest r with 981*r^2 <= z*100*2^F, one result bit per
  // cycle from the top. rsq holds 981*r^2, rlin holds 2*981*r shifted up to the
  // trial bit, rinc holds 981 times the trial bit squared.
  localparam int RB  = 14 + (FRAC_BITS + 1) / 2;
  localparam int SQW = 2 * RB + 12;
  logic           rbusy;
  logic [4:0]     rcnt;
  logic [SQW-1:0] rnum, rsq, rlin, rinc, rtry;
  logic [RB-1:0]  rres;

  assign rtry = rsq + rlin + rinc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rbusy <= 1'b0;
      sts.root_done <= 1'b0;
    end else begin
      sts.root_done <= 1'b0;
      if (cmd.root_start) begin
        rbusy <= 1'b1;
        rcnt  <= 5'(RB - 1);
        rnum  <= (body[SLOT_POS_Z] > 0) ?
                 SQW'(64'(unsigned'(body[SLOT_POS_Z])) * 64'd100 << FRAC_BITS) : '0;
        rsq   <= '0;
        rlin  <= '0;
        rinc  <= SQW'(981) << (2 * (RB - 1));
        rres  <= '0;
      end else if (rbusy) begin
        if (rtry <= rnum) begin
          rsq  <= rtry;
          rlin <= (rlin >> 1) + rinc;
          rres <= {rres[RB-2:0], 1'b1};
        end else begin
          rlin <= rlin >> 1;
          rres <= {rres[RB-2:0], 1'b0};
        end
        rinc <= rinc >> 2;
        rcnt <= rcnt - 5'd1;
        if (rcnt == 5'd0) begin
          rbusy <= 1'b0;
          sts.root_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sts.root_done) root <= 33'(rres);
  end

  // Operand selection and product.
  logic signed [33:0] opa, opb;
  logic signed [67:0] prod;
  logic signed [ACCW-1:0] term;

  always_comb begin
    case (cmd.asel)
      SA_STANCE: opa = 34'(signed'({1'b0, stance_time}));
      SA_GAIN:   opa = 34'(signed'({1'b0, velocity_gain}));
      SA_ROOT:   opa = 34'(root);
      default:   opa = 34'(body_a);
    endcase
    case (cmd.bsel)
      SB_FOOT: opb = 34'(foot[cmd.bidx[1:0]]);
      SB_PF:   opb = 34'(pf[cmd.bidx[1:0]]);
      SB_TANG: opb = 34'(tang[cmd.bidx[0]]);
      SB_HIP: begin
        if (cmd.bidx[0] == 1'b0)
          opb = leg[0] ? 34'(signed'({1'b0, hip_x_offset}))
                       : -34'(signed'({1'b0, hip_x_offset}));
        else
          opb = leg[1] ? -34'(signed'({1'b0, hip_y_offset}))
                       : 34'(signed'({1'b0, hip_y_offset}));
      end
      SB_VELERR: opb = 34'(body_a) - 34'(body_b);
      default: opb = 34'(body_b);
    endcase
  end

  logic signed [67:0] prod_r;
  assign prod = opa * opb;
  always_ff @(posedge clk) prod_r <= prod;

  logic half_r, neg_r, mac_r, body_r;
  logic signed [31:0] bodyb_r;
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_r <= 1'b0;
    end else begin
      mac_r <= cmd.mac_en;
    end
    half_r  <= cmd.half;
    neg_r   <= cmd.neg;
    body_r  <= cmd.add_body;
    bodyb_r <= body_b;
  end

  always_comb begin
    if (body_r)
      term = ACCW'(bodyb_r);
    else if (half_r)
      term = ACCW'(prod_r >>> (FRAC_BITS + 1));
    else
      term = ACCW'(prod_r >>> FRAC_BITS);
    if (neg_r) term = -term;
  end

  function automatic logic signed [31:0] sat(input logic signed [ACCW-1:0] v);
    if (v > ACCW'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -ACCW'(64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) acc <= '0;
    else if (mac_r) acc <= acc + term;
    if (cmd.store) begin
      case (cmd.dst)
        DST_PF: pf[cmd.dst_idx] <= sat(acc);
        DST_TANG: tang[cmd.dst_idx[0]] <= sat(acc);
        default: begin
          if (cmd.dst_idx[0]) target_y <= sat(acc);
          else target_x <= sat(acc);
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/rfp_ctrl.sv =====
// Controller: sequences the multiply-accumulate program for one planned leg.
module rfp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic              out_taken,
  input  rfp_pkg::rfp_sts_t sts,
  output rfp_pkg::rfp_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import rfp_pkg::*;

  rfp_state_t state, state_next;
  logic [4:0] step, step_next;
  logic [1:0] idx, idx_next;

  // Step counts: pf 3 products + 2 drain; tang 2 + 2; target 7 + 3.
  always_comb begin
    state_next = state;
    step_next  = step;
    idx_next   = idx;
    case (state)
      ST_IDLE: if (go) begin state_next = ST_ROOT; end
      ST_ROOT: if (sts.root_done) begin
        state_next = ST_MAC; step_next = '0; idx_next = '0;
      end
      ST_MAC: begin
        step_next = step + 5'd1;
        if (step == 5'd4) begin
          step_next = '0;
          idx_next = idx + 2'd1;
          if (idx == 2'd2) begin state_next = ST_TANG; idx_next = '0; end
        end
      end
      ST_TANG: begin
        step_next = step + 5'd1;
        if (step == 5'd3) begin
          step_next = '0;
          idx_next = idx + 2'd1;
          if (idx == 2'd1) begin state_next = ST_TGT; idx_next = '0; end
        end
      end
      ST_TGT: begin
        step_next = step + 5'd1;
        if (step == 5'd9) begin
          step_next = '0;
          idx_next = idx + 2'd1;
          if (idx == 2'd1) state_next = ST_OUT;
        end
      end
      ST_OUT: if (out_taken) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.asel = SA_BODY;
    cmd.bsel = SB_BODY;
    cmd.dst = DST_PF;
    cmd.start = (state == ST_IDLE) && go;
    cmd.root_start = cmd.start;
    cmd.dst_idx = idx;
    case (state)
      ST_MAC: begin
        cmd.acc_clr = (step == 5'd0);
        cmd.bsel = SB_FOOT;
        cmd.mac_en = (step < 5'd3);
        cmd.aidx = 5'(3 * idx + step);
        cmd.bidx = step;
        cmd.dst = DST_PF;
        cmd.store = (step == 5'd4);
      end
      ST_TANG: begin
        // x: w16*pf2 - w17*pf1 ; y: w17*pf0 - w15*pf2
        cmd.acc_clr = (step == 5'd0);
        cmd.bsel = SB_PF;
        cmd.mac_en = (step < 5'd2);
        cmd.neg = (step == 5'd1);
        if (idx == 2'd0) begin
          cmd.aidx = (step == 5'd0) ? 5'd16 : 5'd17;
          cmd.bidx = (step == 5'd0) ? 5'd2 : 5'd1;
        end else begin
          cmd.aidx = (step == 5'd0) ? 5'd17 : 5'd15;
          cmd.bidx = (step == 5'd0) ? 5'd0 : 5'd2;
        end
        cmd.dst = DST_TANG;
        cmd.store = (step == 5'd3);
      end
      ST_TGT: begin
        cmd.acc_clr = (step == 5'd0);
        cmd.mac_en = (step < 5'd7);
        cmd.dst = DST_TGT;
        cmd.store = (step == 5'd8);
        case (step)
          5'd0: begin cmd.bsel = SB_HIP; cmd.aidx = 5'(3 * idx); cmd.bidx = 5'd0; end
          5'd1: begin cmd.bsel = SB_HIP; cmd.aidx = 5'(3 * idx + 1); cmd.bidx = 5'd1; end
          5'd2: begin cmd.add_body = 1'b1; cmd.bidx = 5'(9 + idx); end
          5'd3: begin
            cmd.asel = SA_STANCE; cmd.half = 1'b1; cmd.bidx = 5'(12 + idx);
          end
          5'd4: begin
            cmd.asel = SA_GAIN; cmd.bsel = SB_VELERR;
            cmd.aidx = 5'(12 + idx); cmd.bidx = 5'(18 + idx);
          end
          5'd5: begin
            cmd.asel = SA_STANCE; cmd.bsel = SB_TANG; cmd.half = 1'b1;
            cmd.bidx = 5'(idx);
          end
          5'd6: begin
            cmd.asel = SA_ROOT; cmd.half = 1'b1; cmd.bidx = 5'(12 + idx);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

endmodule

// ===== sim/raibert_foothold_planner_test.sv =====
// Self-checking testbench for the foothold planner: directed and random stimulus.
module raibert_foothold_planner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfp_pkg::*;

  localparam bit MODE_BODY = 1'b0;
  localparam bit MODE_LEG  = 1'b1;
  localparam int SLOT_POS = 9, SLOT_VEL = 12, SLOT_OMEGA = 15, SLOT_VDES = 18;
  localparam longint ONE = 65536;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    bit        mode;
    bit [4:0]  slot;
    bit [31:0] value;
    bit [1:0]  leg;
    bit        swing;
    bit [31:0] fx, fy, fz;
  } gait_item_t;

  typedef struct {
    logic [1:0]  leg;
    logic [31:0] x, y;
  } foothold_t;

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [71:0]  m_axis_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_idx;
  logic [19:0]  cfg_data;

  raibert_foothold_planner u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Planner state mirror
  longint body_word[BODY_WORDS];
  bit     swing_prev[4];
  bit     leg_seen[4];
  longint stance_t, vel_gain, hip_x, hip_y;

  foothold_t foothold_q[$];
  int  errors, items_sent, plans_checked, ignored_items;
  int  idle_cnt = 0;
  bit  no_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b, int sh);
    return (a * b) >>> sh;  // arithmetic shift floors
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - res - b;
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // Returns 1 and the foothold when the item plans a leg.
  function automatic bit plan_foothold(gait_item_t it, output foothold_t fh);
    longint hp[2], ft[3], pf[3], tg[2], vel, acc, z, rt;
    bit plan;
    fh = '{default: '0};
    if (it.mode == MODE_BODY) begin
      if (it.slot < BODY_WORDS) body_word[it.slot] = longint'($signed(it.value));
      return 0;
    end
    plan = leg_seen[it.leg] ? (!swing_prev[it.leg] && it.swing) : it.swing;
    leg_seen[it.leg] = 1;
    swing_prev[it.leg] = it.swing;
    if (!plan) return 0;
    hp[0] = it.leg[0] ? hip_x : -hip_x;
    hp[1] = it.leg[1] ? -hip_y : hip_y;
    ft[0] = longint'($signed(it.fx));
    ft[1] = longint'($signed(it.fy));
    ft[2] = longint'($signed(it.fz));
    for (int i = 0; i < 3; i++)
      pf[i] = sat32(fx_mul(body_word[3*i], ft[0], 16) + fx_mul(body_word[3*i+1], ft[1], 16) +
                    fx_mul(body_word[3*i+2], ft[2], 16));
    // omega x (R*foot), x and y components only
    tg[0] = sat32(fx_mul(body_word[SLOT_OMEGA+1], pf[2], 16) -
                  fx_mul(body_word[SLOT_OMEGA+2], pf[1], 16));
    tg[1] = sat32(fx_mul(body_word[SLOT_OMEGA+2], pf[0], 16) -
                  fx_mul(body_word[SLOT_OMEGA], pf[2], 16));
    z = body_word[SLOT_POS_Z];
    rt = (z > 0) ? int_sqrt(((z <<< 16) * 100) / 981) : 0;
    fh.leg = it.leg;
    for (int i = 0; i < 2; i++) begin
      vel = body_word[SLOT_VEL+i];
      acc = fx_mul(body_word[3*i], hp[0], 16) + fx_mul(body_word[3*i+1], hp[1], 16) +
            body_word[SLOT_POS+i];
      acc += fx_mul(stance_t, vel, 17);
      acc += fx_mul(vel_gain, vel - body_word[SLOT_VDES+i], 16);
      acc += fx_mul(stance_t, tg[i], 17);
      acc += fx_mul(rt, vel, 17);
      if (i == 0) fh.x = 32'(sat32(acc));
      else        fh.y = 32'(sat32(acc));
    end
    return 1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(gait_item_t it);
    int gap;
    foothold_t fh;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= {it.fz, it.fy, it.fx, it.swing, it.leg, it.value, it.slot};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (it.mode == MODE_BODY && it.slot >= BODY_WORDS) ignored_items++;
    if (plan_foothold(it, fh)) foothold_q.push_back(fh);
  endtask

  // Stop sending, wait for every foothold, then let a plan in flight finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (foothold_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      REG_STANCE: stance_t = val;
      REG_GAIN:   vel_gain = val[16:0];
      REG_HIP_X:  hip_x    = val[16:0];
      REG_HIP_Y:  hip_y    = val[16:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_body(int slot, longint val);
    gait_item_t it;
    it = '{mode: MODE_BODY, slot: 5'(slot), value: 32'(val),
           leg: 2'($urandom), swing: 1'($urandom),
           fx: $urandom, fy: $urandom, fz: $urandom};
    send_item(it);
  endtask

  task automatic leg_update(int leg, bit sw, longint fx, longint fy, longint fz);
    gait_item_t it;
    it = '{mode: MODE_LEG, slot: 5'($urandom), value: $urandom, leg: 2'(leg),
           swing: sw, fx: 32'(fx), fy: 32'(fy), fz: 32'(fz)};
    send_item(it);
  endtask

  function automatic longint rand_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return longint'($signed($urandom));
    if (r == 1) return ($urandom_range(0, 1) != 0) ? I32_MAX : I32_MIN;
    return longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
  endfunction

  task automatic load_level_body();
    for (int s = 0; s < BODY_WORDS; s++)
      set_body(s, (s == 0 || s == 4 || s == 8) ? ONE :
                  (s == SLOT_POS_Z) ? 32'sd29491 : longint'($urandom_range(0, 2 * ONE)) - ONE);
  endtask

  // Reset register values; first sighting in swing and a stance-to-swing move both plan.
  task automatic test_defaults();
    load_level_body();
    leg_update(0, 1, -ONE / 4, ONE / 8, -ONE / 3);
    leg_update(1, 1, ONE / 4, ONE / 8, -ONE / 3);
    leg_update(2, 0, -ONE / 4, -ONE / 8, -ONE / 3);
    leg_update(3, 0, ONE / 4, -ONE / 8, -ONE / 3);
    leg_update(2, 1, -ONE / 5, -ONE / 8, -ONE / 3);
    leg_update(3, 1, ONE / 5, -ONE / 8, -ONE / 3);
    leg_update(0, 1, 0, 0, 0);   // swing held: no plan
    leg_update(0, 0, 0, 0, 0);
    leg_update(0, 1, ONE, ONE, ONE);
  endtask

  // Saturation, field extremes, ignored slots, non-positive height.
  task automatic test_extremes();
    set_body(21, 0);
    set_body(31, -1);
    set_body(SLOT_POS_Z, -ONE);
    leg_update(1, 0, 0, 0, 0);
    leg_update(1, 1, I32_MAX, I32_MIN, I32_MAX);
    set_body(SLOT_POS_Z, 0);
    leg_update(1, 0, 0, 0, 0);
    leg_update(1, 1, I32_MIN, I32_MAX, I32_MIN);
    set_body(0, I32_MAX);
    set_body(1, I32_MIN);
    set_body(SLOT_VEL, I32_MAX);
    set_body(SLOT_OMEGA + 2, I32_MIN);
    set_body(SLOT_POS_Z, I32_MAX);
    leg_update(3, 0, 0, 0, 0);
    leg_update(3, 1, I32_MAX, I32_MAX, I32_MIN);
    set_body(SLOT_VEL + 1, I32_MIN);
    set_body(SLOT_VDES, I32_MAX);
    leg_update(2, 0, 0, 0, 0);
    leg_update(2, 1, I32_MIN, I32_MIN, I32_MAX);
  endtask

  task automatic test_random(int n_items);
    gait_item_t it;
    int r, l;
    for (int n = 0; n < n_items; n++) begin
      if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 25) begin
        set_body((r < 2) ? $urandom_range(BODY_WORDS, 31) : $urandom_range(0, BODY_WORDS - 1),
                 rand_word());
      end else begin
        l = $urandom_range(0, 3);
        it = '{mode: MODE_LEG, slot: 5'($urandom), value: $urandom, leg: 2'(l),
               swing: swing_prev[l] ? ($urandom_range(0, 3) != 0 ? 1'b0 : 1'b1)
                                    : ($urandom_range(0, 2) != 0 ? 1'b1 : 1'b0),
               fx: 32'(rand_word()), fy: 32'(rand_word()), fz: 32'(rand_word())};
        send_item(it);
      end
    end
    no_idle = 0;
  endtask

  task automatic test_register_sweep();
    logic [19:0] st[6] = '{20'd0, 20'd655360, 20'd32768, 20'd1048575, 20'd131072, 20'd0};
    logic [19:0] kg[6] = '{20'd0, 20'd65536, 20'd655, 20'd131071, 20'd3277, 20'd0};
    logic [19:0] hx[6] = '{20'd0, 20'd65536, 20'd12845, 20'd131071, 20'd20000, 20'd0};
    logic [19:0] hy[6] = '{20'd0, 20'd65536, 20'd8323, 20'd131071, 20'd5000, 20'd0};
    for (int p = 0; p < 6; p++) begin
      drain();
      if (p == 5) begin
        st[p] = 20'($urandom_range(0, 655360));
        kg[p] = 20'($urandom_range(0, 65536));
        hx[p] = 20'($urandom_range(0, 65536));
        hy[p] = 20'($urandom_range(0, 65536));
      end
      write_reg(REG_STANCE, st[p]);
      write_reg(REG_GAIN, kg[p]);
      write_reg(REG_HIP_X, hx[p]);
      write_reg(REG_HIP_Y, hy[p]);
      test_random(300);
    end
  endtask

  // Result sink: random backpressure
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 12)) @(posedge clk);
      if (!no_idle) begin
        m_axis_tready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3))
          @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    foothold_t fh, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.leg = m_axis_tdata[1:0];
      got.x   = m_axis_tdata[33:2];
      got.y   = m_axis_tdata[65:34];
      if (foothold_q.size() == 0) begin
        $display("%0t: unexpected foothold leg %0d x %h y %h", $time, got.leg, got.x, got.y);
        errors++;
      end else begin
        fh = foothold_q.pop_front();
        plans_checked++;
        if (got.leg !== fh.leg) begin
          $display("%0t: planned_leg exp %0d act %0d", $time, fh.leg, got.leg);
          errors++;
        end
        if (got.x !== fh.x) begin
          $display("%0t: target_x leg %0d exp %h act %h", $time, fh.leg, fh.x, got.x);
          errors++;
        end
        if (got.y !== fh.y) begin
          $display("%0t: target_y leg %0d exp %h act %h", $time, fh.leg, fh.y, got.y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d footholds outstanding", $time, foothold_q.size());
      $display("raibert_foothold_planner_test: FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    errors = 0;
    items_sent = 0;
    plans_checked = 0;
    ignored_items = 0;
    no_idle = 0;
    stance_t = 32768;
    vel_gain = 655;
    hip_x = 12845;
    hip_y = 8323;
    foreach (body_word[i]) body_word[i] = 0;
    foreach (leg_seen[i]) begin
      leg_seen[i] = 0;
      swing_prev[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_extremes();
    drain();   // sender holds off until every foothold is back
    load_level_body();
    test_register_sweep();
    drain();

    $display("Sent %0d transactions (%0d to unused slots), checked %0d footholds,",
             items_sent, ignored_items, plans_checked);
    $display("over six register settings including all-zero and maximum values.");
    if (errors == 0 && foothold_q.size() == 0) begin
      $display("raibert_foothold_planner_test: PASS");
    end else begin
      $display("%0d mismatches, %0d footholds never arrived", errors, foothold_q.size());
      $display("raibert_foothold_planner_test: FAIL");
    end
    $finish;
  end

endmodule
